FILE: src/e2r_pkg.sv
`default_nettype none

package e2r_pkg;

    // angle and stream widths
    localparam int ANGLE_W      = 16;
    localparam int Q16_W        = 18;
    localparam int N_ENTRIES    = 9;
    localparam int S_TDATA_W    = 3 * ANGLE_W;
    localparam int MAT_W        = N_ENTRIES * Q16_W;
    localparam int M_TDATA_W    = ((MAT_W + 7) / 8) * 8;

    // cordic datapath: x and y in Q30, z in units of 2^-32 turn
    localparam int CORDIC_STEPS = 30;
    localparam int XY_W         = 33;
    localparam int Z_W          = 34;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    // matrix datapath
    localparam int PROD2_W      = 2 * Q16_W - 2;
    localparam int PROD3_W      = Q16_W + PROD2_W;
    localparam int ACC_W        = PROD3_W + 2;
    localparam int MATRIX_LAT   = 3;
    localparam int PIPE_LAT     = CORDIC_LAT + MATRIX_LAT;

    typedef logic signed [Q16_W-1:0] q16_t;
    typedef logic signed [XY_W-1:0]  xy_t;
    typedef logic signed [Z_W-1:0]   z_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // gain-corrected 1.0 in Q30
    localparam xy_t  X_INIT  = 33'sh26DD3B6A;
    localparam q16_t ONE_Q16 = 18'sd65536;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            24:      v = 32'h00000029;
            25:      v = 32'h00000014;
            26:      v = 32'h0000000A;
            27:      v = 32'h00000005;
            28:      v = 32'h00000003;
            29:      v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // round half up by an arithmetic right shift, then clamp to +-1.0
    function automatic q16_t round_sat(input acc_t v, input int unsigned sh);
        acc_t r;
        q16_t q;
        r = (v + (acc_t'(1) <<< (sh - 1))) >>> sh;
        if (r > acc_t'(ONE_Q16)) begin
            q = ONE_Q16;
        end else if (r < -acc_t'(ONE_Q16)) begin
            q = -ONE_Q16;
        end else begin
            q = r[Q16_W-1:0];
        end
        return q;
    endfunction

endpackage

`default_nettype wire

FILE: src/e2r_cordic.sv
`default_nettype none

module e2r_cordic (
    input  wire logic                        aclk,
    input  wire logic                        en,
    input  wire logic [e2r_pkg::ANGLE_W-1:0] angle,
    output e2r_pkg::q16_t                    sin_q16,
    output e2r_pkg::q16_t                    cos_q16
);
    import e2r_pkg::*;

    xy_t  x_reg    [CORDIC_STEPS+1];
    xy_t  y_reg    [CORDIC_STEPS+1];
    z_t   z_reg    [CORDIC_STEPS+1];
    logic flip_reg [CORDIC_STEPS+1];
    q16_t sin_reg;
    q16_t cos_reg;

    logic        flip_next;
    logic [31:0] ang_next;

    // fold second and third quadrant by half a turn
    assign flip_next = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
    assign ang_next  = {angle[ANGLE_W-1] ^ flip_next, angle[ANGLE_W-2:0],
                        {(32 - ANGLE_W){1'b0}}};

    // stage zero: start vector and signed angle
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= X_INIT;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed({{(Z_W - 32){ang_next[31]}}, ang_next});
            flip_reg[0] <= flip_next;
        end
    end

    // one rotation step per stage
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        localparam z_t ATAN = z_t'(atan_entry(k));
        xy_t xs;
        xy_t ys;

        assign xs = x_reg[k] >>> k;
        assign ys = y_reg[k] >>> k;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (!z_reg[k][Z_W-1]) begin
                    x_reg[k+1] <= x_reg[k] - ys;
                    y_reg[k+1] <= y_reg[k] + xs;
                    z_reg[k+1] <= z_reg[k] - ATAN;
                end else begin
                    x_reg[k+1] <= x_reg[k] + ys;
                    y_reg[k+1] <= y_reg[k] - xs;
                    z_reg[k+1] <= z_reg[k] + ATAN;
                end
                flip_reg[k+1] <= flip_reg[k];
            end
        end
    end

    // undo the fold, round Q30 to Q1.16 and clamp
    xy_t x_fin;
    xy_t y_fin;

    assign x_fin = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
    assign y_fin = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= round_sat(acc_t'(x_fin), 14);
            sin_reg <= round_sat(acc_t'(y_fin), 14);
        end
    end

    assign sin_q16 = sin_reg;
    assign cos_q16 = cos_reg;

endmodule

`default_nettype wire

FILE: src/euler_to_rotation_matrix_top.sv
`default_nettype none

// Euler angles to 3x3 rotation matrix (yaw * pitch * roll). Each input
// transaction carries three 16-bit binary angles (65536 is a full turn); each
// output transaction carries the nine matrix entries as signed Q1.16 values
// clamped to +-1.0. The block takes one transaction per clock cycle while
// s_tready is high. Between acceptance and m_tvalid an item passes the angle
// set-up register, the 30-step CORDIC for sine and cosine, the rounding
// register, the multiply, accumulate and round stages of the matrix terms,
// and the output register. A two-entry output buffer lets s_tready stay high
// while a finished result waits; s_tready falls only once that buffer is full.
module euler_to_rotation_matrix_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // yaw_angle, pitch_angle, roll_angle
    input  wire logic [e2r_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2,
    // zero padding
    output logic [e2r_pkg::M_TDATA_W-1:0]      m_tdata
);
    import e2r_pkg::*;

    logic en;
    logic [PIPE_LAT-1:0] vld_reg;

    logic             out_vld_reg, out_vld_next;
    logic             skid_vld_reg, skid_vld_next;
    logic [MAT_W-1:0] out_data_reg, out_data_next;
    logic [MAT_W-1:0] skid_data_reg, skid_data_next;

    q16_t sy, cy, sp, cp, sr, cr;

    // pipeline moves whenever the skid entry is free
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // sine and cosine of each angle
    e2r_cordic u_yaw (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[ANGLE_W-1:0]),
        .sin_q16 (sy),
        .cos_q16 (cy)
    );

    e2r_cordic u_pitch (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[2*ANGLE_W-1:ANGLE_W]),
        .sin_q16 (sp),
        .cos_q16 (cp)
    );

    e2r_cordic u_roll (
        .aclk    (aclk),
        .en      (en),
        .angle   (s_tdata[3*ANGLE_W-1:2*ANGLE_W]),
        .sin_q16 (sr),
        .cos_q16 (cr)
    );

    // first matrix stage: all two-factor products
    logic signed [PROD2_W-1:0] spcy_reg, spsy_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;
    logic signed [PROD2_W-1:0] crsy_reg, srsy_reg, crcy_reg, srcy_reg;
    q16_t sr1_reg, cr1_reg, nsp1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            spcy_reg <= PROD2_W'(sp) * PROD2_W'(cy);
            spsy_reg <= PROD2_W'(sp) * PROD2_W'(sy);
            cpcy_reg <= PROD2_W'(cp) * PROD2_W'(cy);
            cpsy_reg <= PROD2_W'(cp) * PROD2_W'(sy);
            srcp_reg <= PROD2_W'(sr) * PROD2_W'(cp);
            crcp_reg <= PROD2_W'(cr) * PROD2_W'(cp);
            crsy_reg <= PROD2_W'(cr) * PROD2_W'(sy);
            srsy_reg <= PROD2_W'(sr) * PROD2_W'(sy);
            crcy_reg <= PROD2_W'(cr) * PROD2_W'(cy);
            srcy_reg <= PROD2_W'(sr) * PROD2_W'(cy);
            sr1_reg  <= sr;
            cr1_reg  <= cr;
            nsp1_reg <= -sp;
        end
    end

    // second matrix stage: three-factor products, two-factor entries rounded
    logic signed [PROD3_W-1:0] t01_reg, t02_reg, t11_reg, t12_reg;
    logic signed [PROD2_W-1:0] crsy2_reg, srsy2_reg, crcy2_reg, srcy2_reg;
    q16_t r0c0_2_reg, r1c0_2_reg, r2c0_2_reg, r2c1_2_reg, r2c2_2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            t01_reg    <= PROD3_W'(sr1_reg) * PROD3_W'(spcy_reg);
            t02_reg    <= PROD3_W'(cr1_reg) * PROD3_W'(spcy_reg);
            t11_reg    <= PROD3_W'(sr1_reg) * PROD3_W'(spsy_reg);
            t12_reg    <= PROD3_W'(cr1_reg) * PROD3_W'(spsy_reg);
            crsy2_reg  <= crsy_reg;
            srsy2_reg  <= srsy_reg;
            crcy2_reg  <= crcy_reg;
            srcy2_reg  <= srcy_reg;
            r0c0_2_reg <= round_sat(acc_t'(cpcy_reg), 16);
            r1c0_2_reg <= round_sat(acc_t'(cpsy_reg), 16);
            r2c1_2_reg <= round_sat(acc_t'(srcp_reg), 16);
            r2c2_2_reg <= round_sat(acc_t'(crcp_reg), 16);
            r2c0_2_reg <= nsp1_reg;
        end
    end

    // third matrix stage: add the scaled two-factor term, round from Q48
    q16_t r0c0_reg, r0c1_reg, r0c2_reg, r1c0_reg, r1c1_reg, r1c2_reg;
    q16_t r2c0_reg, r2c1_reg, r2c2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            r0c1_reg <= round_sat(acc_t'(t01_reg) - (acc_t'(crsy2_reg) <<< 16), 32);
            r0c2_reg <= round_sat(acc_t'(t02_reg) + (acc_t'(srsy2_reg) <<< 16), 32);
            r1c1_reg <= round_sat(acc_t'(t11_reg) + (acc_t'(crcy2_reg) <<< 16), 32);
            r1c2_reg <= round_sat(acc_t'(t12_reg) - (acc_t'(srcy2_reg) <<< 16), 32);
            r0c0_reg <= r0c0_2_reg;
            r1c0_reg <= r1c0_2_reg;
            r2c0_reg <= r2c0_2_reg;
            r2c1_reg <= r2c1_2_reg;
            r2c2_reg <= r2c2_2_reg;
        end
    end

    logic [MAT_W-1:0] mat_word;

    assign mat_word = {r2c2_reg, r2c1_reg, r2c0_reg, r1c2_reg, r1c1_reg, r1c0_reg,
                       r0c2_reg, r0c1_reg, r0c0_reg};

    // output register with one skid entry behind it
    always_comb begin
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_data_next  = out_data_reg;
        skid_data_next = skid_data_reg;
        if (skid_vld_reg) begin
            if (m_tready) begin
                out_data_next = skid_data_reg;
                skid_vld_next = 1'b0;
            end
        end else if (vld_reg[PIPE_LAT-1]) begin
            if (!out_vld_reg || m_tready) begin
                out_data_next = mat_word;
                out_vld_next  = 1'b1;
            end else begin
                skid_data_next = mat_word;
                skid_vld_next  = 1'b1;
            end
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(M_TDATA_W - MAT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

FILE: src/e2r_checker.sv
`default_nettype none

module e2r_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [e2r_pkg::M_TDATA_W-1:0] m_tdata
);
    import e2r_pkg::*;

    // no result is shown in the cycle after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // input side only stalls when a result is already waiting
    a_stall_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // input side reopens only after a result transaction drains the buffer
    a_reopen_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(s_tready) |-> $past(m_tvalid && m_tready))
        else $error("input reopened without an output transaction");

    // a stalled result holds its value
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // first and last entries stay within +-1.0
    a_entry_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[Q16_W-1:0]) <= ONE_Q16)
                  && ($signed(m_tdata[Q16_W-1:0]) >= -ONE_Q16)
                  && ($signed(m_tdata[MAT_W-1:MAT_W-Q16_W]) <= ONE_Q16)
                  && ($signed(m_tdata[MAT_W-1:MAT_W-Q16_W]) >= -ONE_Q16))
        else $error("matrix entry out of range");

endmodule

bind euler_to_rotation_matrix_top e2r_checker u_e2r_checker (.*);

`default_nettype wire

FILE: verif/euler_to_rotation_matrix_top_tb.sv
module euler_to_rotation_matrix_top_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int ANG_W        = e2r_pkg::ANGLE_W;
    localparam int ENT_W        = e2r_pkg::Q16_W;
    localparam int N_ENT        = e2r_pkg::N_ENTRIES;
    localparam int MAT_BITS     = N_ENT * ENT_W;
    localparam int TAIL_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int N_STEPS      = 30;
    localparam longint UNIT_Q16 = 65536;
    localparam longint X_START  = 64'sh26DD3B6A;

    // arctangent of 2^-i, units of 2^-32 turn
    localparam longint ATAN_TURN [N_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    // directed angles, packed as {roll, pitch, yaw}
    localparam int N_DIRECTED = 20;
    localparam logic [3*ANG_W-1:0] DIRECTED_ANGLES [N_DIRECTED] = '{
        48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_4000,
        48'h0000_4000_0000, 48'h4000_0000_0000, 48'h8000_8000_8000,
        48'hC000_C000_C000, 48'hBFFF_7FFF_3FFF, 48'hC001_8001_4001,
        48'h2000_2000_2000, 48'h2000_C000_0000, 48'h6000_4000_BFFF,
        48'h9ABC_5678_1234, 48'h8000_0000_FFFF, 48'hFFFF_3FFF_7FFF,
        48'h6000_A000_E000, 48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA,
        48'h0001_FFFF_8001, 48'h7FFF_C000_4000
    };

    localparam string ENTRY_NAME [N_ENT] = '{
        "r0c0", "r0c1", "r0c2", "r1c0", "r1c1", "r1c2", "r2c0", "r2c1", "r2c2"
    };

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [e2r_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [e2r_pkg::M_TDATA_W-1:0]  m_tdata;

    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          error_count;
    int          result_count;
    int unsigned cycle_count;

    // predicted matrices, oldest first
    logic [MAT_BITS-1:0] pending_matrices [$];

    euler_to_rotation_matrix_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > UNIT_Q16) begin
            return UNIT_Q16;
        end else if (v < -UNIT_Q16) begin
            return -UNIT_Q16;
        end
        return v;
    endfunction

    // cordic sine and cosine of a binary angle, Q1.16
    function automatic void sine_cosine(input logic [ANG_W-1:0] ang,
                                        output longint sn, output longint cs);
        logic [31:0] a;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        a    = {ang, 16'h0000};
        flip = (ang[15:14] == 2'b01) || (ang[15:14] == 2'b10);
        // second and third quadrants rotate by half a turn, negate afterwards
        if (flip) begin
            a = a + 32'h8000_0000;
        end
        z = longint'($signed(a));
        x = X_START;
        y = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ATAN_TURN[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ATAN_TURN[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = clamp_unit(round_half_up(x, 14));
        sn = clamp_unit(round_half_up(y, 14));
    endfunction

    function automatic longint two_term(input longint a, input longint b);
        return clamp_unit(round_half_up(a * b, 16));
    endfunction

    function automatic longint three_term(input longint a, input longint b, input longint c,
                                          input longint d, input longint e,
                                          input longint sgn);
        return clamp_unit(round_half_up(a * b * c + sgn * d * e * UNIT_Q16, 32));
    endfunction

    // expected matrix for one set of angles, entries packed from r0c0 up
    function automatic logic [MAT_BITS-1:0] predict_matrix(input logic [ANG_W-1:0] yaw,
                                                           input logic [ANG_W-1:0] pitch,
                                                           input logic [ANG_W-1:0] roll);
        longint              sy, cy, sp, cp, sr, cr;
        longint              ent [N_ENT];
        logic [MAT_BITS-1:0] m;
        sine_cosine(yaw, sy, cy);
        sine_cosine(pitch, sp, cp);
        sine_cosine(roll, sr, cr);
        ent[0] = two_term(cp, cy);
        ent[1] = three_term(sr, sp, cy, cr, sy, -1);
        ent[2] = three_term(cr, sp, cy, sr, sy, 1);
        ent[3] = two_term(cp, sy);
        ent[4] = three_term(sr, sp, sy, cr, cy, 1);
        ent[5] = three_term(cr, sp, sy, sr, cy, -1);
        ent[6] = clamp_unit(-sp);
        ent[7] = two_term(sr, cp);
        ent[8] = two_term(cr, cp);
        for (int k = 0; k < N_ENT; k++) begin
            m[k*ENT_W +: ENT_W] = ent[k][ENT_W-1:0];
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // result checker
    always @(posedge aclk) begin : check_result
        logic [MAT_BITS-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_matrices.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = pending_matrices.pop_front();
                for (int k = 0; k < N_ENT; k++) begin
                    if (m_tdata[k*ENT_W +: ENT_W] !== want[k*ENT_W +: ENT_W]) begin
                        report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                            result_count, ENTRY_NAME[k],
                            $signed(m_tdata[k*ENT_W +: ENT_W]),
                            $signed(want[k*ENT_W +: ENT_W])));
                    end
                end
                if (m_tdata[e2r_pkg::M_TDATA_W-1:MAT_BITS] !== '0) begin
                    report_mismatch($sformatf("result %0d: padding bits not zero",
                        result_count));
                end
            end
            result_count++;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // one input transaction, with random idle cycles ahead of it
    task automatic send_angles(input logic [ANG_W-1:0] yaw,
                               input logic [ANG_W-1:0] pitch,
                               input logic [ANG_W-1:0] roll);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {roll, pitch, yaw};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_matrices.push_back(predict_matrix(yaw, pitch, roll));
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_matrices.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // mostly uniform, some just around the octant boundaries
    function automatic logic [ANG_W-1:0] rand_angle();
        int v;
        if ($urandom_range(9) < 3) begin
            v = int'($urandom_range(7)) * 8192 + int'($urandom_range(6)) - 3;
        end else begin
            v = int'($urandom_range(16'hFFFF));
        end
        return v[ANG_W-1:0];
    endfunction

    task automatic test_directed_angles();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_angles(DIRECTED_ANGLES[i][15:0], DIRECTED_ANGLES[i][31:16],
                        DIRECTED_ANGLES[i][47:32]);
        end
        wait_for_results();
    endtask

    task automatic test_random_angles(input int count, input int idle_pct,
                                      input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) begin
            send_angles(rand_angle(), rand_angle(), rand_angle());
        end
    endtask

    // sender holds off until the pipeline has fully drained, then resumes
    task automatic test_pause_until_drained();
        test_random_angles(20, 35, 35);
        wait_for_results();
        test_random_angles(20, 35, 35);
    endtask

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        m_tready           = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        error_count        = 0;
        result_count       = 0;
        cycle_count        = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_angles();
        test_random_angles(120, 0, 0);
        test_random_angles(120, 86, 0);
        test_pause_until_drained();
        test_random_angles(120, 0, 86);
        test_random_angles(120, 35, 35);
        wait_for_results();

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/e2r_pkg.sv
src/e2r_cordic.sv
src/euler_to_rotation_matrix_top.sv
src/e2r_checker.sv
verif/euler_to_rotation_matrix_top_tb.sv
